// ===== hw/rtl/bqc_pkg.sv =====
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared types, sizes and Q14 helpers for the biquad cascade.
// ----------------------------------------------------------------------------
package bqc_pkg;

    localparam int MAX_SECTIONS = 8;
    localparam int TAPS         = 5;
    localparam int COEF_DEPTH   = MAX_SECTIONS * TAPS;
    localparam int COEF_AW      = $clog2(COEF_DEPTH);
    localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int DLY_AW       = SEC_W + 1;
    localparam int DLY_DEPTH    = 2 ** DLY_AW;
    localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);

    localparam int SAMPLE_W     = 16;
    localparam int IDX_W        = 6;
    localparam int CFG_W        = 4;
    localparam int ACC_W        = 21;
    localparam int RND_W        = 19;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 16;

    // coefficient positions within a section
    localparam int POS_C0 = 0;
    localparam int POS_C1 = 1;
    localparam int POS_C2 = 2;
    localparam int POS_C3 = 3;
    localparam int POS_C4 = 4;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic {
        CMD_FILTER = 1'b0,
        CMD_COEF   = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR,
        ST_FB0,
        ST_FB1,
        ST_FF0,
        ST_FF1,
        ST_FF2,
        ST_SUM,
        ST_DONE
    } state_t;

    // (p + 0x2000) >>> 14
    function automatic logic signed [RND_W-1:0] rnd_q14(input logic signed [31:0] p);
        logic signed [32:0] s;
        s = {p[31], p} + 33'sh2000;
        return s[32:14];
    endfunction

    // p >>> 14, low 16 bits only (feedforward sum wraps)
    function automatic logic [SAMPLE_W-1:0] trn_q14(input logic signed [31:0] p);
        return p[29:14];
    endfunction

    // asymmetric clamp of the recursive node
    function automatic sample_t clamp_node(input logic signed [ACC_W-1:0] a);
        if (a > ACC_W'(32'sh7fff)) begin
            return 16'sh7fff;
        end else if (a <= -ACC_W'(32'sh8000)) begin
            return -16'sh7fff;
        end else begin
            return a[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/bqc_ram.sv =====
// ----------------------------------------------------------------------------
// bqc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bqc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/biquad_df2_saturating_cascade.sv =====
// ----------------------------------------------------------------------------
// biquad_df2_saturating_cascade
// Cascade of Q14 direct form II biquads on one shared 16x16 multiplier.
// ----------------------------------------------------------------------------
//
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------------
//  s_       | in        | sample to filter, or one coefficient word (tuser)
//  m_       | out       | filtered sample, one beat per sample beat
//  cfg_     | in        | sections_in_use (4 bits)
//
//  Sequencing: a sample beat runs through N sections, N = sections in use (capped at
//  MAX_SECTIONS); each section is seven steps of the one multiplier and the
//  two registered-read RAMs. A coefficient beat is written as it is accepted.
//  Reset: aresetn is synchronous, active low; the delay store reads as zero
//  through per-entry valid flags, so no clearing pass is needed.
//  Stalls: s_tready is low while a sample is in the sections or waiting for
//  the output register; the output register frees as soon as m_tready is high.
//
module biquad_df2_saturating_cascade (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bqc_pkg::CFG_W-1:0]     cfg_data,     // sections_in_use
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bqc_pkg::S_TDATA_W-1:0] s_tdata,      // [15:0] sample_in,
                                                        // [21:16] coeff_index,
                                                        // [37:22] coeff_value,
                                                        // [39:38] zero
    input  logic                          s_tuser,      // [0] command
    input  logic                          s_tlast,      // block_end_in
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bqc_pkg::M_TDATA_W-1:0] m_tdata,      // [15:0] sample_out
    output logic                          m_tlast       // block_end_out
);

    localparam int SW = bqc_pkg::SAMPLE_W;
    localparam int CA = bqc_pkg::COEF_AW;
    localparam int DA = bqc_pkg::DLY_AW;
    localparam int NW = bqc_pkg::CNT_W;
    localparam int EW = bqc_pkg::SEC_W;
    localparam int AW = bqc_pkg::ACC_W;

    // ---------------- input beat fields ----------------
    bqc_pkg::cmd_t           s_cmd;
    bqc_pkg::sample_t        s_sample;
    logic [bqc_pkg::IDX_W-1:0] s_idx;
    logic [SW-1:0]           s_coef;

    assign s_cmd    = bqc_pkg::cmd_t'(s_tuser);
    assign s_sample = s_tdata[15:0];
    assign s_idx    = s_tdata[21:16];
    assign s_coef   = s_tdata[37:22];

    // ---------------- registers ----------------
    bqc_pkg::state_t state_reg, state_next;

    logic [bqc_pkg::CFG_W-1:0] sections_reg;
    logic [NW-1:0]             n_reg, n_next;
    logic [EW-1:0]             sec_reg, sec_next;
    bqc_pkg::sample_t          x_reg, x_next;       // running section input
    bqc_pkg::sample_t          w1_reg, w1_next;
    bqc_pkg::sample_t          w2_reg, w2_next;
    bqc_pkg::sample_t          w_reg, w_next;       // clamped recursive node
    logic signed [AW-1:0]      acc_reg, acc_next;
    logic [SW-1:0]             ff_reg, ff_next;     // wrapping feedforward sum
    logic signed [31:0]        prod_reg, prod_next;
    logic                      last_reg, last_next; // block end mark in flight
    logic [bqc_pkg::DLY_DEPTH-1:0] dly_vld_reg;
    logic                      dly_rvld_reg;
    logic                      m_tvalid_reg;
    logic [SW-1:0]             m_tdata_reg;
    logic                      m_tlast_reg;

    logic s_acc;
    logic out_free;
    logic sec_last;

    assign s_acc    = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;
    assign sec_last = (NW'(sec_reg) + NW'(1)) == n_reg;

    // ---------------- RAM ports ----------------
    logic          coef_we;
    logic [CA-1:0] coef_waddr;
    logic [CA-1:0] coef_raddr;
    logic [SW-1:0] coef_rdata;
    logic          dly_we;
    logic [DA-1:0] dly_waddr;
    logic [SW-1:0] dly_wdata;
    logic [DA-1:0] dly_raddr;
    logic [SW-1:0] dly_rdata;
    logic [2:0]    coef_pos;
    logic          dly_odd;
    bqc_pkg::sample_t dly_eff;
    bqc_pkg::sample_t mul_b;

    assign coef_we    = s_acc && (s_cmd == bqc_pkg::CMD_COEF)
                        && (int'(s_idx) < bqc_pkg::COEF_DEPTH);
    assign coef_waddr = CA'(s_idx);
    assign coef_raddr = CA'(CA'(sec_reg) * CA'(bqc_pkg::TAPS) + CA'(coef_pos));
    assign dly_raddr  = {sec_reg, dly_odd};
    assign dly_eff    = dly_rvld_reg ? bqc_pkg::sample_t'(dly_rdata) : '0;

    bqc_ram #(
        .WIDTH (SW),
        .DEPTH (bqc_pkg::COEF_DEPTH)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (s_coef),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    bqc_ram #(
        .WIDTH (SW),
        .DEPTH (bqc_pkg::DLY_DEPTH)
    ) u_dly_ram (
        .aclk  (aclk),
        .we    (dly_we),
        .waddr (dly_waddr),
        .wdata (dly_wdata),
        .raddr (dly_raddr),
        .rdata (dly_rdata)
    );

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bqc_pkg::ST_IDLE: begin
                if (s_acc && (s_cmd == bqc_pkg::CMD_FILTER)) begin
                    state_next = (sections_reg == '0) ? bqc_pkg::ST_DONE
                                                      : bqc_pkg::ST_ADDR;
                end
            end
            bqc_pkg::ST_ADDR: state_next = bqc_pkg::ST_FB0;
            bqc_pkg::ST_FB0:  state_next = bqc_pkg::ST_FB1;
            bqc_pkg::ST_FB1:  state_next = bqc_pkg::ST_FF0;
            bqc_pkg::ST_FF0:  state_next = bqc_pkg::ST_FF1;
            bqc_pkg::ST_FF1:  state_next = bqc_pkg::ST_FF2;
            bqc_pkg::ST_FF2:  state_next = bqc_pkg::ST_SUM;
            bqc_pkg::ST_SUM: begin
                state_next = sec_last ? bqc_pkg::ST_DONE : bqc_pkg::ST_ADDR;
            end
            bqc_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = bqc_pkg::ST_IDLE;
                end
            end
            default: state_next = bqc_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    // read order: c0/w1, c2/w2, c1, c3, c4; both RAM reads are registered
    always_comb begin
        coef_pos  = 3'(bqc_pkg::POS_C0);
        dly_odd   = 1'b0;
        mul_b     = dly_eff;
        dly_we    = 1'b0;
        dly_waddr = {sec_reg, 1'b0};
        dly_wdata = w2_reg;
        s_tready  = 1'b0;
        case (state_reg)
            bqc_pkg::ST_IDLE: s_tready = 1'b1;
            bqc_pkg::ST_ADDR: begin
                coef_pos = 3'(bqc_pkg::POS_C0);
                dly_odd  = 1'b0;
            end
            bqc_pkg::ST_FB0: begin
                coef_pos = 3'(bqc_pkg::POS_C2);
                dly_odd  = 1'b1;
                mul_b    = dly_eff;                  // c0 * w1
            end
            bqc_pkg::ST_FB1: begin
                coef_pos = 3'(bqc_pkg::POS_C1);
                mul_b    = dly_eff;                  // c2 * w2
            end
            bqc_pkg::ST_FF0: begin
                coef_pos = 3'(bqc_pkg::POS_C3);
                mul_b    = w1_reg;                   // c1 * w1
            end
            bqc_pkg::ST_FF1: begin
                coef_pos  = 3'(bqc_pkg::POS_C4);
                mul_b     = w2_reg;                  // c3 * w2
                dly_we    = 1'b1;                    // w1 <- w2
                dly_waddr = {sec_reg, 1'b0};
                dly_wdata = w2_reg;
            end
            bqc_pkg::ST_FF2: begin
                mul_b     = w_reg;                   // c4 * w
                dly_we    = 1'b1;                    // w2 <- w
                dly_waddr = {sec_reg, 1'b1};
                dly_wdata = w_reg;
            end
            bqc_pkg::ST_SUM:  mul_b = w_reg;
            bqc_pkg::ST_DONE: mul_b = w_reg;
            default:          mul_b = dly_eff;
        endcase
    end

    assign cfg_ready = 1'b1;

    // ---------------- datapath ----------------
    always_comb begin
        prod_next = $signed(coef_rdata) * mul_b;
        n_next    = n_reg;
        sec_next  = sec_reg;
        x_next    = x_reg;
        w1_next   = w1_reg;
        w2_next   = w2_reg;
        w_next    = w_reg;
        acc_next  = acc_reg;
        ff_next   = ff_reg;
        last_next = last_reg;
        case (state_reg)
            bqc_pkg::ST_IDLE: begin
                if (s_acc && (s_cmd == bqc_pkg::CMD_FILTER)) begin
                    x_next    = s_sample;
                    last_next = s_tlast;
                    sec_next  = '0;
                    n_next    = (int'(sections_reg) > bqc_pkg::MAX_SECTIONS)
                                ? NW'(bqc_pkg::MAX_SECTIONS) : NW'(sections_reg);
                end
            end
            bqc_pkg::ST_FB0: w1_next = dly_eff;
            bqc_pkg::ST_FB1: begin
                w2_next  = dly_eff;
                acc_next = AW'(x_reg) + AW'(bqc_pkg::rnd_q14(prod_reg));
            end
            bqc_pkg::ST_FF0: acc_next = acc_reg + AW'(bqc_pkg::rnd_q14(prod_reg));
            bqc_pkg::ST_FF1: begin
                w_next  = bqc_pkg::clamp_node(acc_reg);
                ff_next = bqc_pkg::trn_q14(prod_reg);
            end
            bqc_pkg::ST_FF2: ff_next = ff_reg + bqc_pkg::trn_q14(prod_reg);
            bqc_pkg::ST_SUM: begin
                x_next   = ff_reg + bqc_pkg::trn_q14(prod_reg);
                sec_next = sec_reg + EW'(1);
            end
            default: begin
                x_next = x_reg;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bqc_pkg::ST_IDLE;
            sections_reg <= '0;
            dly_vld_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                sections_reg <= cfg_data;
            end
            if (dly_we) begin
                dly_vld_reg[dly_waddr] <= 1'b1;
            end
            if (state_reg == bqc_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        sec_reg      <= sec_next;
        x_reg        <= x_next;
        w1_reg       <= w1_next;
        w2_reg       <= w2_next;
        w_reg        <= w_next;
        acc_reg      <= acc_next;
        ff_reg       <= ff_next;
        prod_reg     <= prod_next;
        last_reg     <= last_next;
        dly_rvld_reg <= dly_vld_reg[dly_raddr];
        if (state_reg == bqc_pkg::ST_DONE && out_free) begin
            m_tdata_reg <= x_reg;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: Q14 direct form II biquad cascade testbench
// Sends sample and coefficient beats with random idle cycles on both stream
// sides. A predictor keeps its own coefficient words, delay nodes and section
// count. It computes each filtered sample, and the scoreboard compares it
// with the output beats in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bqc_pkg::*;

    // Worst sample beat at full section depth, plus margin.
    localparam int DRAIN_CYCLES = 2 + 7 * MAX_SECTIONS + 8;
    localparam int IDLE_PCT     = 38;
    localparam int PHASES       = 16;
    localparam int PHASE_BEATS  = 66;
    localparam int PRINT_CAP    = 50;
    localparam longint Q14_HALF = 64'sh2000;
    localparam longint NODE_MAX = 32767;
    localparam longint NODE_MIN = -32768;

    // One input beat, before packing onto tdata/tuser/tlast.
    typedef struct {
        cmd_t               command;
        sample_t            sample;
        logic [IDX_W-1:0]   slot;
        sample_t            coef;
        logic               block_end;
    } beat_t;

    // One output beat as the cascade should produce it.
    typedef struct {
        sample_t sample;
        logic    block_end;
    } filtered_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;  // [15:0] sample_in, [21:16] coeff_index,
                                             // [37:22] coeff_value, [39:38] zero
    logic                   s_tuser   = 1'b0; // [0] command
    logic                   s_tlast   = 1'b0; // block_end_in
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;         // [15:0] sample_out
    logic                   m_tlast;         // block_end_out

    beat_t      pending_beats[$];
    filtered_t  expected_samples[$];

    // Predictor state: its own copy of the coefficient words, delay nodes
    // (older / newer per section) and the section count register.
    sample_t    tap_words[COEF_DEPTH];
    sample_t    node_older[MAX_SECTIONS] = '{default: '0};
    sample_t    node_newer[MAX_SECTIONS] = '{default: '0};
    logic [CFG_W-1:0] sections_now = '0;

    bit         s_taken = 1'b0;   // input beat accepted at the last rising edge
    bit         steady  = 1'b0;   // no idling on either side while set
    int         errors          = 0;
    int         samples_checked = 0;
    int         tap_writes      = 0;
    int         stray_writes    = 0;
    int         setting_writes  = 0;
    int         node_clamps     = 0;

    biquad_df2_saturating_cascade i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Generous limit on the whole run.
    initial begin
        #5ms;
        $display("timeout: stimulus or results stuck, %0d results still due",
                 expected_samples.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Runs one sample through the sections in use and advances the delay
    // nodes. Recursive products round (add half, floor shift by 14), the
    // feedforward products only floor shift, the node clamps to +/-0x7fff and
    // the section output wraps to 16 bits.
    function automatic sample_t cascade_filter(input sample_t x_in);
        longint  acc, ff, older, newer, node;
        sample_t x;
        int      depth;
        x = x_in;
        depth = (sections_now > MAX_SECTIONS) ? MAX_SECTIONS : int'(sections_now);
        for (int s = 0; s < depth; s++) begin
            older = node_older[s];
            newer = node_newer[s];
            acc = longint'(x)
                + ((longint'(tap_words[s*TAPS+POS_C0]) * older + Q14_HALF) >>> 14)
                + ((longint'(tap_words[s*TAPS+POS_C2]) * newer + Q14_HALF) >>> 14);
            if (acc > NODE_MAX) begin
                node = NODE_MAX;
                node_clamps++;
            end else if (acc <= NODE_MIN) begin
                // asymmetric: the negative rail is -0x7fff, not -0x8000
                node = -NODE_MAX;
                node_clamps++;
            end else begin
                node = acc;
            end
            ff = ((longint'(tap_words[s*TAPS+POS_C1]) * older) >>> 14)
               + ((longint'(tap_words[s*TAPS+POS_C3]) * newer) >>> 14)
               + ((longint'(tap_words[s*TAPS+POS_C4]) * node) >>> 14);
            node_older[s] = node_newer[s];
            node_newer[s] = node[15:0];
            x = ff[15:0];
        end
        return x;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= PRINT_CAP) begin
            $display("MISMATCH @%0t ns: %s", $time, what);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: input beats change on the falling edge, taken from the queue.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        beat_t b;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (pending_beats.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                b = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, b.coef, b.slot, b.sample};
                s_tuser  <= b.command;
                s_tlast  <= b.block_end;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure, independent of m_tvalid.
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Monitor and scoreboard: everything sampled at the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        beat_t     b;
        filtered_t want;
        s_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sections_now = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                b.command   = cmd_t'(s_tuser);
                b.sample    = s_tdata[15:0];
                b.slot      = s_tdata[21:16];
                b.coef      = s_tdata[37:22];
                b.block_end = s_tlast;
                if (b.command == CMD_COEF) begin
                    // slots beyond the store are dropped by the block
                    if (b.slot < COEF_DEPTH) begin
                        tap_words[b.slot] = b.coef;
                    end
                end else begin
                    want.sample    = cascade_filter(b.sample);
                    want.block_end = b.block_end;
                    expected_samples.push_back(want);
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("output beat %h last %b with nothing due",
                                              m_tdata, m_tlast));
                end else begin
                    want = expected_samples.pop_front();
                    samples_checked++;
                    if (m_tdata !== want.sample) begin
                        report_mismatch($sformatf("sample_out %h, expected %h (sections %0d)",
                                                  m_tdata, want.sample, sections_now));
                    end
                    if (m_tlast !== want.block_end) begin
                        report_mismatch($sformatf("block_end_out %b, expected %b",
                                                  m_tlast, want.block_end));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_sample(input sample_t v, input logic last);
        beat_t b;
        b.command   = CMD_FILTER;
        b.sample    = v;
        b.slot      = IDX_W'($urandom_range(63));      // don't-care fields still toggle
        b.coef      = 16'($urandom_range(65535));
        b.block_end = last;
        pending_beats.push_back(b);
    endtask

    task automatic queue_tap(input int slot, input sample_t v);
        beat_t b;
        b.command   = CMD_COEF;
        b.sample    = 16'($urandom_range(65535));
        b.slot      = IDX_W'(slot);
        b.coef      = v;
        b.block_end = 1'($urandom_range(1));
        pending_beats.push_back(b);
        tap_writes++;
        if (slot >= COEF_DEPTH) begin
            stray_writes++;
        end
    endtask

    // Coefficient word for one position. Tame sets keep the recursive part
    // stable (small poles); wild sets drive the node into the rails often.
    function automatic sample_t tap_value(input int pos, input bit wild);
        if (wild) begin
            return 16'($urandom_range(65535));
        end
        case (pos)
            POS_C0: return 16'($urandom_range('h2800) - 'h1800);
            POS_C2: return 16'($urandom_range('h4000) - 'h2000);
            default: return 16'($urandom_range('h8000) - 'h4000);
        endcase
    endfunction

    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 15) begin
            case ($urandom_range(4))
                0: return 16'sh7fff;
                1: return 16'sh8000;
                2: return 16'sh0000;
                3: return 16'shffff;
                default: return 16'sh0001;
            endcase
        end else if (r < 40) begin
            return 16'($urandom_range(2048) - 1024);
        end
        return 16'($urandom_range(65535));
    endfunction

    // Block is idle once the queue is empty, the last beat is taken and every
    // filtered sample has come back; coefficient beats leave no trace, so wait
    // out a full sample time on top.
    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_tvalid || expected_samples.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_sections(input logic [CFG_W-1:0] n);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        setting_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int plan[PHASES];
        int depth, r;
        bit wild;

        plan = '{1, 2, 8, 0, 3, 15, 5, 4, 9, 6, 7, 2, 1, 8, 12, 3};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // No sections after reset: samples pass straight through, even at the
        // rails, and the delay nodes stay untouched.
        set_sections(0);
        queue_sample(16'sh7fff, 1'b1);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh0000, 1'b0);
        queue_sample(16'shffff, 1'b1);

        // Load every slot before any section filters. Section 0 gets extreme
        // words to push the node to both rails; the rest are tame.
        queue_tap(0 + POS_C0, 16'sh7fff);
        queue_tap(0 + POS_C1, 16'sh8000);
        queue_tap(0 + POS_C2, 16'sh7fff);
        queue_tap(0 + POS_C3, 16'sh7fff);
        queue_tap(0 + POS_C4, 16'sh8000);
        for (int k = TAPS; k < COEF_DEPTH; k++) begin
            queue_tap(k, tap_value(k % TAPS, 1'b0));
        end
        // slots beyond the store: dropped, no result
        queue_tap(COEF_DEPTH, 16'sh1234);
        queue_tap(63, 16'shffff);
        wait_drained();

        // One section, rails in both directions: feedback saturates the node.
        set_sections(1);
        repeat (3) queue_sample(16'sh7fff, 1'b0);
        repeat (3) queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh0000, 1'b1);
        wait_drained();

        // Count above the section limit acts as full depth.
        set_sections(15);
        queue_sample(16'sh7fff, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh0001, 1'b0);
        queue_sample(16'shffff, 1'b1);
        wait_drained();

        // Random phases: each picks a depth, reloads some sections and then
        // streams samples with coefficient updates and dropped writes mixed in.
        for (int p = 0; p < PHASES; p++) begin
            wild   = (p % 4 == 2);
            steady = (p == 5 || p == 6);
            set_sections(CFG_W'(plan[p]));
            depth = (plan[p] > MAX_SECTIONS) ? MAX_SECTIONS : plan[p];
            for (int s = 0; s < depth; s++) begin
                if ($urandom_range(1)) begin
                    for (int k = 0; k < TAPS; k++) begin
                        queue_tap(s * TAPS + k, tap_value(k, wild));
                    end
                end
            end
            for (int k = 0; k < PHASE_BEATS; k++) begin
                r = $urandom_range(99);
                if (r < 88) begin
                    queue_sample(pick_sample(), $urandom_range(7) == 0);
                end else if (r < 96) begin
                    depth = $urandom_range(COEF_DEPTH - 1);
                    queue_tap(depth, tap_value(depth % TAPS, wild));
                end else begin
                    queue_tap($urandom_range(63, COEF_DEPTH), 16'($urandom_range(65535)));
                end
            end
            wait_drained();
            steady = 1'b0;
        end

        $display("covered: %0d samples checked over %0d section-count writes, %0d node clamps",
                 samples_checked, setting_writes, node_clamps);
        $display("covered: %0d coefficient beats, %0d of them to slots past the store",
                 tap_writes, stray_writes);
        if (errors == 0 && expected_samples.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
